FILE: hdl/framed_command_deframer_unit_macros.svh
// Assertion macros for the framed command deframer.
// Expects clk and rst_n in the scope of each use.
`ifndef FRAMED_COMMAND_DEFRAMER_UNIT_MACROS_SVH
`define FRAMED_COMMAND_DEFRAMER_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define FCD_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Condition implies consequence in the next cycle.
`define FCD_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

FILE: hdl/fcd_pkg.sv
// Shared constants and types for the framed command deframer.
// No dependencies.
package fcd_pkg;

  localparam int FRAME_LEN = 4;

  localparam logic [5:0] LAST_INDEX   = 6'(FRAME_LEN - 1);
  localparam logic [7:0] HEADER_BYTE  = 8'hA5;
  localparam logic [7:0] TRAILER_BYTE = 8'h5A;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_BODY    = 3'b010,
    PH_TRAILER = 3'b100
  } fcd_phase_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] speed;
    logic [7:0] turn;
  } fcd_result_t;

endpackage

FILE: hdl/fcd_input_stage.sv
// Input register for received bytes, with stall back to the sender.
// Depends on nothing but the take request formed at the top level.
module fcd_input_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

FILE: hdl/fcd_parser.sv
// Frame parser: header hunt, body capture, running sum and trailer check.
// Depends on fcd_pkg.
module fcd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output fcd_pkg::fcd_result_t result
);
  import fcd_pkg::*;

  fcd_phase_t phase_r;
  fcd_phase_t phase_nxt;
  logic [5:0] count_r;
  logic [5:0] count_nxt;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] first_r;
  logic [7:0] second_r;
  logic [7:0] last_r;
  logic       wr_first;
  logic       wr_second;
  logic       wr_last;
  logic       hit;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    wr_first  = 1'b0;
    wr_second = 1'b0;
    wr_last   = 1'b0;
    hit       = 1'b0;
    case (phase_r)
      PH_BODY: begin
        wr_first  = (count_r == 6'd0);
        wr_second = (count_r == 6'd1);
        count_nxt = count_r + 6'd1;
        if (count_r < LAST_INDEX) begin
          sum_nxt = sum_r + rx_byte;
        end else begin
          wr_last   = 1'b1;
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        hit       = (rx_byte == TRAILER_BYTE) && (sum_r == last_r);
        phase_nxt = PH_HUNT;
      end
      default: begin
        if (rx_byte == HEADER_BYTE) begin
          count_nxt = 6'd0;
          sum_nxt   = 8'd0;
          phase_nxt = PH_BODY;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= 6'd0;
      sum_r   <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_first) begin
      first_r <= rx_byte;
    end
    if (take && wr_second) begin
      second_r <= rx_byte;
    end
    if (take && wr_last) begin
      last_r <= rx_byte;
    end
  end

  assign result.hit   = take && hit;
  assign result.speed = first_r;
  assign result.turn  = second_r;

endmodule

FILE: hdl/fcd_output_stage.sv
// Result register for decoded commands, with stall from the receiver.
// Depends on fcd_pkg.
module fcd_output_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  fcd_pkg::fcd_result_t result,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_speed_command,
  output logic [7:0]          out_turn_command
);
  import fcd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] speed_r;
  logic [7:0] turn_r;

  assign room = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (result.hit) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.hit) begin
      speed_r <= result.speed;
      turn_r  <= result.turn;
    end
  end

  assign out_valid         = valid_r;
  assign out_speed_command = speed_r;
  assign out_turn_command  = turn_r;

endmodule

FILE: hdl/framed_command_deframer_unit.sv
// Framed command deframer top level: input register, parser, result register.
// Depends on fcd_pkg, fcd_input_stage, fcd_parser, fcd_output_stage and the macros header.
//
// Takes one serial byte per transaction and emits a speed/turn command pair for
// every frame of header 0xA5, FRAME_LEN body bytes and trailer 0x5A whose last
// body byte equals the 8-bit sum of the others; bad frames vanish silently.
// One byte is taken every cycle while the input register holds one and the result
// side is not stalling. A command is loaded into the result register by the edge
// that accepts its trailer byte, so each trailer byte passes through the input
// register and then the result register before its command is presented; a
// stalled result holds back the parser, which then holds its input register.
`include "framed_command_deframer_unit_macros.svh"

module framed_command_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_speed_command,
  output logic [7:0] out_turn_command
);
  import fcd_pkg::*;

  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        room;
  logic        take;
  fcd_result_t result;

  assign take = byte_valid && room;

  fcd_input_stage u_input (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  fcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (byte_data),
    .result  (result)
  );

  fcd_output_stage u_output (
    .clk               (clk),
    .rst_n             (rst_n),
    .result            (result),
    .room              (room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed_command (out_speed_command),
    .out_turn_command  (out_turn_command)
  );

  `FCD_ASSERT_SAME(a_stall_needs_byte, in_stall, byte_valid, "stall with empty input register")
  `FCD_ASSERT_SAME(a_hit_needs_room, result.hit, room && byte_valid, "result without room")
  `FCD_ASSERT_NEXT(a_hit_loads, result.hit, out_valid && (out_speed_command == $past(result.speed)) && (out_turn_command == $past(result.turn)), "result not loaded")

endmodule
